// ===== rtl/look_at_view_matrix_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the view matrix pipeline.
// Each macro names the assertion and reports failures through $error.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Same-cycle implication.
`define LCAM_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("lcam assertion failed");

// Next-cycle implication.
`define LCAM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("lcam assertion failed");

`endif

// ===== rtl/lcam_pkg.sv =====
// ----------------------------------------------------------------------------
// lcam_pkg
// Shared constants and width helpers for the view matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lcam_pkg;

  // The largest prescaled magnitude lies in [2^NORM_MSB, 2^(NORM_MSB+1)).
  localparam int NORM_MSB    = 29;
  localparam int MAG_W       = 30;
  localparam int SQ_W        = 63;
  localparam int ROOT_W      = 31;
  localparam int ISQRT_STEPS = 32;
  localparam int UPS_W       = 31;

  localparam int PRE_LAT   = 3;
  localparam int CROSS_LAT = 2;
  localparam int SHIFT_LAT = 4;

  // Width of a signed normalized axis component.
  function automatic int axis_w(input int w, input int f);
    return (f + 2 < w) ? f + 2 : w;
  endfunction

  // Latency of one normalizer.
  function automatic int norm_lat(input int f);
    return PRE_LAT + 2 + ISQRT_STEPS + 1 + (f + 1) + 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/look_at_view_matrix.sv =====
// ----------------------------------------------------------------------------
// look_at_view_matrix
// One request is taken every cycle unless req_stall is high; three normalizers
// in series, each with a bit-per-stage square root and divider, set the depth.
// Reset clears the valid bits and holds off requests; a full output stall
// freezes the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "look_at_view_matrix_defines.svh"

module look_at_view_matrix
  import lcam_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic signed [DATA_WIDTH-1:0] eye_x,
  input  wire logic signed [DATA_WIDTH-1:0] eye_y,
  input  wire logic signed [DATA_WIDTH-1:0] eye_z,
  input  wire logic signed [DATA_WIDTH-1:0] target_x,
  input  wire logic signed [DATA_WIDTH-1:0] target_y,
  input  wire logic signed [DATA_WIDTH-1:0] target_z,
  input  wire logic signed [DATA_WIDTH-1:0] up_x,
  input  wire logic signed [DATA_WIDTH-1:0] up_y,
  input  wire logic signed [DATA_WIDTH-1:0] up_z,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic signed [DATA_WIDTH-1:0]      side_x,
  output logic signed [DATA_WIDTH-1:0]      side_y,
  output logic signed [DATA_WIDTH-1:0]      side_z,
  output logic signed [DATA_WIDTH-1:0]      true_up_x,
  output logic signed [DATA_WIDTH-1:0]      true_up_y,
  output logic signed [DATA_WIDTH-1:0]      true_up_z,
  output logic signed [DATA_WIDTH-1:0]      forward_x,
  output logic signed [DATA_WIDTH-1:0]      forward_y,
  output logic signed [DATA_WIDTH-1:0]      forward_z,
  output logic signed [DATA_WIDTH-1:0]      shift_side,
  output logic signed [DATA_WIDTH-1:0]      shift_up,
  output logic signed [DATA_WIDTH-1:0]      shift_forward
);

  localparam int W    = DATA_WIDTH;
  localparam int AW   = axis_w(DATA_WIDTH, FRAC_BITS);
  localparam int NL   = norm_lat(FRAC_BITS);
  localparam int C1_W = UPS_W + AW + 1;
  localparam int C2_W = 2 * AW + 1;
  localparam int HOP  = CROSS_LAT + NL;
  localparam int TU   = 1 + NL + 2 * HOP;
  localparam int TOT  = TU + SHIFT_LAT;

  logic           en;
  logic [TOT-1:0] vpipe;

  assign en        = !(res_valid && res_stall);
  assign req_stall = rst || !en;
  assign res_valid = vpipe[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[TOT-2:0], req_valid};
    end
  end

  logic [2:0][W:0]   d_r;
  logic [2:0][W-1:0] eye_r;
  logic [2:0][W-1:0] up_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= {eye_x[W-1], eye_x} - {target_x[W-1], target_x};
      d_r[1] <= {eye_y[W-1], eye_y} - {target_y[W-1], target_y};
      d_r[2] <= {eye_z[W-1], eye_z} - {target_z[W-1], target_z};
      eye_r  <= {eye_z, eye_y, eye_x};
      up_r   <= {up_z, up_y, up_x};
    end
  end

  logic [2:0][AW-1:0] fwd;
  logic [2:0][AW-1:0] fwd_s;
  logic [2:0][AW-1:0] fwd_u;
  logic [2:0][AW-1:0] fwd_o;
  logic [2:0][AW-1:0] side;
  logic [2:0][AW-1:0] side_u;
  logic [2:0][AW-1:0] side_o;
  logic [2:0][AW-1:0] upv;
  logic [2:0][AW-1:0] upv_o;
  logic [2:0][W-1:0]  eye_u;
  logic [2:0][W-1:0]  shift;

  lcam_norm #(.IN_W(W + 1), .DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_norm_fwd (
    .clk (clk),
    .en  (en),
    .c   (d_r),
    .o   (fwd)
  );

  logic [2:0][MAG_W-1:0] ups_mag;
  logic [2:0]            ups_sign;
  logic [2:0][MAG_W-1:0] ups_mag_d;
  logic [2:0]            ups_sign_d;
  logic [2:0][UPS_W-1:0] ups;

  lcam_prescale #(.IN_W(W)) u_pre_up (
    .clk  (clk),
    .en   (en),
    .c    (up_r),
    .mag  (ups_mag),
    .sign (ups_sign),
    .nz   ()
  );

  lcam_delay #(.WIDTH(3 * MAG_W + 3), .DEPTH(NL - PRE_LAT)) u_dly_up (
    .clk (clk),
    .en  (en),
    .d   ({ups_mag, ups_sign}),
    .q   ({ups_mag_d, ups_sign_d})
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ups[i] = ups_sign_d[i] ? (~{1'b0, ups_mag_d[i]} + UPS_W'(1)) : {1'b0, ups_mag_d[i]};
    end
  end

  logic [2:0][C1_W-1:0] c1;
  logic [2:0][C2_W-1:0] c2;

  lcam_cross #(.A_W(UPS_W), .B_W(AW)) u_cross_side (
    .clk (clk),
    .en  (en),
    .a   (ups),
    .b   (fwd),
    .o   (c1)
  );

  lcam_norm #(.IN_W(C1_W), .DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_norm_side (
    .clk (clk),
    .en  (en),
    .c   (c1),
    .o   (side)
  );

  lcam_delay #(.WIDTH(3 * AW), .DEPTH(HOP)) u_dly_fwd_s (
    .clk (clk),
    .en  (en),
    .d   (fwd),
    .q   (fwd_s)
  );

  lcam_cross #(.A_W(AW), .B_W(AW)) u_cross_up (
    .clk (clk),
    .en  (en),
    .a   (fwd_s),
    .b   (side),
    .o   (c2)
  );

  lcam_norm #(.IN_W(C2_W), .DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_norm_up (
    .clk (clk),
    .en  (en),
    .c   (c2),
    .o   (upv)
  );

  lcam_delay #(.WIDTH(3 * AW), .DEPTH(HOP)) u_dly_fwd_u (
    .clk (clk),
    .en  (en),
    .d   (fwd_s),
    .q   (fwd_u)
  );

  lcam_delay #(.WIDTH(3 * AW), .DEPTH(HOP)) u_dly_side_u (
    .clk (clk),
    .en  (en),
    .d   (side),
    .q   (side_u)
  );

  lcam_delay #(.WIDTH(3 * W), .DEPTH(TU - 1)) u_dly_eye (
    .clk (clk),
    .en  (en),
    .d   (eye_r),
    .q   (eye_u)
  );

  lcam_shift #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_shift (
    .clk   (clk),
    .en    (en),
    .eye   (eye_u),
    .side  (side_u),
    .up    (upv),
    .fwd   (fwd_u),
    .shift (shift)
  );

  lcam_delay #(.WIDTH(9 * AW), .DEPTH(SHIFT_LAT)) u_dly_axes (
    .clk (clk),
    .en  (en),
    .d   ({fwd_u, upv, side_u}),
    .q   ({fwd_o, upv_o, side_o})
  );

  assign side_x        = W'($signed(side_o[0]));
  assign side_y        = W'($signed(side_o[1]));
  assign side_z        = W'($signed(side_o[2]));
  assign true_up_x     = W'($signed(upv_o[0]));
  assign true_up_y     = W'($signed(upv_o[1]));
  assign true_up_z     = W'($signed(upv_o[2]));
  assign forward_x     = W'($signed(fwd_o[0]));
  assign forward_y     = W'($signed(fwd_o[1]));
  assign forward_z     = W'($signed(fwd_o[2]));
  assign shift_side    = shift[0];
  assign shift_up      = shift[1];
  assign shift_forward = shift[2];

  `LCAM_ASSERT_NEXT(a_freeze, clk, rst, !en, $stable(vpipe))

endmodule

`default_nettype wire

// ===== rtl/lcam_delay.sv =====
// ----------------------------------------------------------------------------
// lcam_delay
// Enabled shift line that aligns side data with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lcam_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/lcam_prescale.sv =====
// ----------------------------------------------------------------------------
// lcam_prescale
// Three-stage block scaling of a signed 3-vector by a common power of two.
// ----------------------------------------------------------------------------
`default_nettype none

`include "look_at_view_matrix_defines.svh"

module lcam_prescale
  import lcam_pkg::*;
#(
  parameter int IN_W = 33
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [2:0][IN_W-1:0]        c,
  output logic      [2:0][MAG_W-1:0]       mag,
  output logic      [2:0]                  sign,
  output logic                             nz
);

  localparam int PW = $clog2(IN_W);
  localparam int MW = (IN_W > MAG_W) ? IN_W : MAG_W;

  logic [2:0][IN_W-1:0] m1;
  logic [2:0]           s1;
  logic [IN_W-1:0]      mx1;
  logic [2:0][IN_W-1:0] m2;
  logic [2:0]           s2;
  logic [PW-1:0]        pos2;
  logic                 nz2;

  logic [2:0][IN_W-1:0] m_c;
  logic [IN_W-1:0]      mx_c;
  logic [PW-1:0]        pos_c;
  logic [2:0][MAG_W-1:0] sh_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_c[i] = c[i][IN_W-1] ? (~c[i] + IN_W'(1)) : c[i];
    end
    mx_c = m_c[0];
    if (m_c[1] > mx_c) begin
      mx_c = m_c[1];
    end
    if (m_c[2] > mx_c) begin
      mx_c = m_c[2];
    end
  end

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (mx1[i]) begin
        pos_c = PW'(i);
      end
    end
  end

  always_comb begin
    logic [7:0]    pos8;
    logic [MW-1:0] ext;
    pos8 = 8'(pos2);
    for (int i = 0; i < 3; i++) begin
      ext = MW'(m2[i]);
      if (pos8 >= 8'(NORM_MSB)) begin
        ext = ext >> (pos8 - 8'(NORM_MSB));
      end else begin
        ext = ext << (8'(NORM_MSB) - pos8);
      end
      sh_c[i] = ext[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1   <= m_c;
      mx1  <= mx_c;
      s1   <= {c[2][IN_W-1], c[1][IN_W-1], c[0][IN_W-1]};
      m2   <= m1;
      s2   <= s1;
      pos2 <= pos_c;
      nz2  <= (mx1 != '0);
      mag  <= sh_c;
      sign <= s2;
      nz   <= nz2;
    end
  end

  `LCAM_ASSERT_IMPLY(a_pre_msb, clk, 1'b0, nz, mag[0][NORM_MSB] || mag[1][NORM_MSB] || mag[2][NORM_MSB])

endmodule

`default_nettype wire

// ===== rtl/lcam_norm.sv =====
// ----------------------------------------------------------------------------
// lcam_norm
// Pipelined vector normalizer: prescale, sum of squares, bit-per-stage
// square root and bit-per-stage rounded division for all three lanes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "look_at_view_matrix_defines.svh"

module lcam_norm
  import lcam_pkg::*;
#(
  parameter int IN_W       = 33,
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          en,
  input  wire logic [2:0][IN_W-1:0]                          c,
  output logic      [2:0][axis_w(DATA_WIDTH, FRAC_BITS)-1:0] o
);

  localparam int AW = axis_w(DATA_WIDTH, FRAC_BITS);
  localparam int F  = FRAC_BITS;
  localparam int W  = DATA_WIDTH;
  localparam int EW = (F + 2 > W) ? F + 2 : W;
  localparam int NUM_W = MAG_W + F + 1;
  localparam logic signed [EW-1:0] MAXV = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [EW-1:0] MINV = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic [2:0][MAG_W-1:0] pm;
  logic [2:0]            psg;
  logic                  pnz;

  lcam_prescale #(.IN_W(IN_W)) u_pre (
    .clk  (clk),
    .en   (en),
    .c    (c),
    .mag  (pm),
    .sign (psg),
    .nz   (pnz)
  );

  logic [2:0][2*MAG_W-1:0] sq;
  logic [2:0][MAG_W-1:0]   sq_m;
  logic [2:0]              sq_sg;
  logic                    sq_nz;

  logic [SQ_W-1:0]       rn   [ISQRT_STEPS+1];
  logic [SQ_W-1:0]       rr   [ISQRT_STEPS+1];
  logic [2:0][MAG_W-1:0] rm   [ISQRT_STEPS+1];
  logic [2:0]            rsg  [ISQRT_STEPS+1];
  logic                  rnz  [ISQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= pm[i] * pm[i];
      end
      sq_m   <= pm;
      sq_sg  <= psg;
      sq_nz  <= pnz;
      rn[0]  <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
      rr[0]  <= '0;
      rm[0]  <= sq_m;
      rsg[0] <= sq_sg;
      rnz[0] <= sq_nz;
    end
  end

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (ISQRT_STEPS - 1 - k));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rn[k] >= rr[k] + BITV) begin
          rn[k+1] <= rn[k] - (rr[k] + BITV);
          rr[k+1] <= (rr[k] >> 1) + BITV;
        end else begin
          rn[k+1] <= rn[k];
          rr[k+1] <= rr[k] >> 1;
        end
        rm[k+1]  <= rm[k];
        rsg[k+1] <= rsg[k];
        rnz[k+1] <= rnz[k];
      end
    end
  end

  logic [ROOT_W-1:0] root;
  assign root = rr[ISQRT_STEPS][ROOT_W-1:0];

  logic [2:0][ROOT_W-1:0] dv_rem [F+2];
  logic [2:0][F:0]        dv_lo  [F+2];
  logic [2:0][F:0]        dv_q   [F+2];
  logic [ROOT_W-1:0]      dv_s   [F+2];
  logic [2:0]             dv_sg  [F+2];
  logic                   dv_nz  [F+2];

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] numer;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        numer = {1'b0, rm[ISQRT_STEPS][i], {F{1'b0}}} + NUM_W'(root >> 1);
        dv_rem[0][i] <= ROOT_W'(numer[NUM_W-1:F+1]);
        dv_lo[0][i]  <= numer[F:0];
        dv_q[0][i]   <= '0;
      end
      dv_s[0]  <= root;
      dv_sg[0] <= rsg[ISQRT_STEPS];
      dv_nz[0] <= rnz[ISQRT_STEPS];
    end
  end

  for (genvar j = 0; j <= F; j++) begin : g_div
    always_ff @(posedge clk) begin
      logic [ROOT_W:0] trial;
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          trial = {dv_rem[j][i], dv_lo[j][i][F]};
          if (trial >= {1'b0, dv_s[j]}) begin
            dv_rem[j+1][i] <= ROOT_W'(trial - {1'b0, dv_s[j]});
            dv_q[j+1][i]   <= {dv_q[j][i][F-1:0], 1'b1};
          end else begin
            dv_rem[j+1][i] <= trial[ROOT_W-1:0];
            dv_q[j+1][i]   <= {dv_q[j][i][F-1:0], 1'b0};
          end
          dv_lo[j+1][i] <= {dv_lo[j][i][F-1:0], 1'b0};
        end
        dv_s[j+1]  <= dv_s[j];
        dv_sg[j+1] <= dv_sg[j];
        dv_nz[j+1] <= dv_nz[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [F+1:0] qs;
    logic signed [EW-1:0] ve;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qs = $signed({1'b0, dv_q[F+1][i]});
        if (dv_sg[F+1][i]) begin
          qs = -qs;
        end
        ve = EW'(qs);
        if (ve > MAXV) begin
          ve = MAXV;
        end else if (ve < MINV) begin
          ve = MINV;
        end
        o[i] <= dv_nz[F+1] ? ve[AW-1:0] : '0;
      end
    end
  end

  `LCAM_ASSERT_IMPLY(a_root_range, clk, 1'b0, dv_nz[0], dv_s[0][ROOT_W-1] || dv_s[0][ROOT_W-2])

endmodule

`default_nettype wire

// ===== rtl/lcam_cross.sv =====
// ----------------------------------------------------------------------------
// lcam_cross
// Two-stage signed cross product: six products, then three differences.
// ----------------------------------------------------------------------------
`default_nettype none

module lcam_cross #(
  parameter int A_W = 31,
  parameter int B_W = 18
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [2:0][A_W-1:0]        a,
  input  wire logic [2:0][B_W-1:0]        b,
  output logic      [2:0][A_W+B_W:0]      o
);

  localparam int PW = A_W + B_W;

  logic signed [PW-1:0] p [6];

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= $signed(a[1]) * $signed(b[2]);
      p[1] <= $signed(a[2]) * $signed(b[1]);
      p[2] <= $signed(a[2]) * $signed(b[0]);
      p[3] <= $signed(a[0]) * $signed(b[2]);
      p[4] <= $signed(a[0]) * $signed(b[1]);
      p[5] <= $signed(a[1]) * $signed(b[0]);
      o[0] <= (PW+1)'(p[0]) - (PW+1)'(p[1]);
      o[1] <= (PW+1)'(p[2]) - (PW+1)'(p[3]);
      o[2] <= (PW+1)'(p[4]) - (PW+1)'(p[5]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcam_shift.sv =====
// ----------------------------------------------------------------------------
// lcam_shift
// Translation column: negated eye dot each axis, rounded and saturated,
// with the eye split into two partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module lcam_shift
  import lcam_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          en,
  input  wire logic [2:0][DATA_WIDTH-1:0]                    eye,
  input  wire logic [2:0][axis_w(DATA_WIDTH, FRAC_BITS)-1:0] side,
  input  wire logic [2:0][axis_w(DATA_WIDTH, FRAC_BITS)-1:0] up,
  input  wire logic [2:0][axis_w(DATA_WIDTH, FRAC_BITS)-1:0] fwd,
  output logic      [2:0][DATA_WIDTH-1:0]                    shift
);

  localparam int AW = axis_w(DATA_WIDTH, FRAC_BITS);
  localparam int W  = DATA_WIDTH;
  localparam int H  = DATA_WIDTH / 2;
  localparam int PW = W + AW;
  localparam int SW = W + AW + 3;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic [2:0][2:0][AW-1:0] ax;
  assign ax[0] = side;
  assign ax[1] = up;
  assign ax[2] = fwd;

  logic signed [H+AW:0]     pl   [3][3];
  logic signed [W-H+AW-1:0] ph   [3][3];
  logic signed [PW-1:0]     prod [3][3];
  logic signed [SW-1:0]     acc  [3];

  always_ff @(posedge clk) begin
    logic signed [SW-1:0] sh;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          pl[a][i]   <= $signed({1'b0, eye[i][H-1:0]}) * $signed(ax[a][i]);
          ph[a][i]   <= $signed(eye[i][W-1:H]) * $signed(ax[a][i]);
          prod[a][i] <= (PW'(ph[a][i]) <<< H) + PW'(pl[a][i]);
        end
        acc[a] <= HALF - (SW'(prod[a][0]) + SW'(prod[a][1]) + SW'(prod[a][2]));
        sh = acc[a] >>> FRAC_BITS;
        if (sh > MAXV) begin
          shift[a] <= MAXV[W-1:0];
        end else if (sh < MINV) begin
          shift[a] <= MINV[W-1:0];
        end else begin
          shift[a] <= sh[W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire
